// ----- sv/shp_pkg.sv -----
package shp_pkg;

   localparam int REQ_BITS = 3;
   localparam int IDX_BITS = 6;
   localparam int KEYF_BITS = 32;
   localparam int CNTF_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;

   // store sizes and datapath widths of the core
   localparam int MAX_BINS = 64;
   localparam int KEY_BITS = KEYF_BITS;
   localparam int COUNT_BITS = CNTF_BITS;

   typedef enum logic [REQ_BITS-1:0] {
      REQ_WRITE_SPLIT = 3'd0,
      REQ_CLEAR       = 3'd1,
      REQ_COUNT       = 3'd2,
      REQ_READ        = 3'd3,
      REQ_PLACE       = 3'd4
   } req_code_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_BIN_MODE  = 4'h0,
      CSR_NUM_BINS  = 4'h4,
      CSR_FIRST_KEY = 4'h8,
      CSR_LAST_KEY  = 4'hC
   } csr_addr_type;

   // request word carried between front and back
   typedef struct packed {
      logic [REQ_BITS-1:0]  req_type;
      logic [IDX_BITS-1:0]  bin_index;
      logic [KEYF_BITS-1:0] key_value;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [IDX_BITS-1:0]  bin_number;
      logic [CNTF_BITS-1:0] bin_count;
      logic [CNTF_BITS-1:0] dest_slot;
      logic                 out_of_range;
   } rsp_word_type;

   // configuration seen by the core
   typedef struct packed {
      logic       bin_mode;
      logic [6:0] num_bins;
      logic [31:0] first_key;
      logic [31:0] last_key;
   } cfg_type;

endpackage

// ----- sv/shp_if.sv -----
interface shp_req_if;
   import shp_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface shp_rsp_if;
   import shp_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/shp_front.sv -----
// accepts request words and queues them for the back end
module shp_front #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  shp_pkg::req_word_type in_word,
   output logic                 q_valid,
   input  logic                 q_pop,
   output shp_pkg::req_word_type q_word
);
   import shp_pkg::*;

   localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   req_word_type     mem_ff [DEPTH];
   logic [PB-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [PB:0]      cnt_ff, cnt_in;
   logic             push;

   assign in_ready = (cnt_ff != (PB+1)'(DEPTH));
   assign push = in_valid && in_ready;
   assign q_valid = (cnt_ff != '0);
   assign q_word = mem_ff[rp_ff];

   // pointer update
   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == PB'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
      end
      if (q_pop && q_valid) begin
         rp_in = (rp_ff == PB'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      end
      cnt_in = cnt_ff + (PB+1)'(push) - (PB+1)'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_word;
      end
   end

endmodule

// ----- sv/shp_back.sv -----
// executes one request at a time: bin search / division, counts, offsets
module shp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  shp_pkg::cfg_type      cfg,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  shp_pkg::req_word_type q_word,
   output logic                  out_valid,
   input  logic                  out_ready,
   output shp_pkg::rsp_word_type out_word
);
   import shp_pkg::*;

   localparam int BB = $clog2(MAX_BINS);
   localparam int NB = BB + 1;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   localparam logic [KEY_BITS-1:0] KMASK = '1;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_DECODE = 9'b000000010,
      ST_SPLIT  = 9'b000000100,
      ST_STEP   = 9'b000001000,
      ST_QUOT   = 9'b000010000,
      ST_BINRD  = 9'b000100000,
      ST_APPLY  = 9'b001000000,
      ST_CLEAR  = 9'b010000000,
      ST_PREFIX = 9'b100000000
   } state_type;

   state_type            state_ff;
   req_word_type         req_ff;
   logic [NB-1:0]        nb_ff;
   logic [BB-1:0]        idx_ff;
   logic [KEY_BITS-1:0]  key_m;
   logic [KEY_BITS-1:0]  lo, hi;

   // stores
   logic [KEY_BITS-1:0]   split_mem [MAX_BINS];
   logic [COUNT_BITS-1:0] count_mem [MAX_BINS];
   logic [COUNT_BITS-1:0] offs_mem [MAX_BINS];
   logic [MAX_BINS-1:0]   cvalid_ff;
   logic                  phase_ff;

   logic [KEY_BITS-1:0]   split_rd_ff;
   logic [COUNT_BITS-1:0] count_rd_ff, offs_rd_ff;
   logic                  crd_valid_ff;
   logic                  rd_ok_ff;

   // divider
   logic [KEY_BITS-1:0]   dvd_ff, dvs_ff;
   logic [KEY_BITS:0]     rem_ff;
   logic [$clog2(KEY_BITS+1)-1:0] dcnt_ff;
   logic                  miss_ff;
   logic [BB-1:0]         bin_ff;
   logic [COUNT_BITS-1:0] run_ff;
   logic                  rsp_full_ff;
   rsp_word_type          rsp_ff;

   logic [NB-1:0] nb_use;
   logic [KEY_BITS:0] rem_sh;
   logic [KEY_BITS-1:0] quo_bits;

   assign key_m = req_ff.key_value[KEY_BITS-1:0] & KMASK;
   assign lo = cfg.first_key[KEY_BITS-1:0];
   assign hi = cfg.last_key[KEY_BITS-1:0];
   assign rem_sh = {rem_ff[KEY_BITS-1:0], dvd_ff[KEY_BITS-1]};
   // quotient once the last bit is in
   assign quo_bits = {dvd_ff[KEY_BITS-2:0], rem_sh >= {1'b0, dvs_ff}};

   always_comb begin
      if (cfg.num_bins < 7'd2) begin
         nb_use = NB'(2);
      end else if (32'(cfg.num_bins) > 32'(MAX_BINS)) begin
         nb_use = NB'(MAX_BINS);
      end else begin
         nb_use = NB'(cfg.num_bins);
      end
   end

   assign out_valid = rsp_full_ff;
   assign out_word = rsp_ff;
   assign q_pop = (state_ff == ST_IDLE) && q_valid && !rsp_full_ff;

   function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] a,
                                                     logic [COUNT_BITS-1:0] b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_BITS] ? CMAX : s[COUNT_BITS-1:0];
   endfunction

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_full_ff <= 1'b0;
         cvalid_ff <= '0;
         phase_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (rsp_full_ff && out_ready) begin
            rsp_full_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  req_ff <= q_word;
                  nb_ff <= nb_use;
                  idx_ff <= '0;
                  rsp_ff <= '0;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               case (req_ff.req_type)
                  REQ_WRITE_SPLIT: begin
                     if (32'(req_ff.bin_index) < 32'(MAX_BINS)) begin
                        split_mem[req_ff.bin_index[BB-1:0]] <= key_m;
                     end
                     rsp_ff.bin_number <= req_ff.bin_index;
                     rsp_full_ff <= 1'b1;
                     state_ff <= ST_IDLE;
                  end
                  REQ_CLEAR: begin
                     cvalid_ff <= '0;
                     phase_ff <= 1'b0;
                     rsp_full_ff <= 1'b1;
                     state_ff <= ST_IDLE;
                  end
                  REQ_READ: begin
                     if (32'(req_ff.bin_index) < 32'(MAX_BINS)) begin
                        bin_ff <= req_ff.bin_index[BB-1:0];
                        state_ff <= ST_BINRD;
                     end else begin
                        rsp_ff.out_of_range <= 1'b1;
                        rsp_full_ff <= 1'b1;
                        state_ff <= ST_IDLE;
                     end
                  end
                  REQ_COUNT, REQ_PLACE: begin
                     if (req_ff.req_type == REQ_COUNT) begin
                        phase_ff <= 1'b0;
                     end
                     if (req_ff.req_type == REQ_PLACE && !phase_ff) begin
                        run_ff <= '0;
                        idx_ff <= '0;
                        state_ff <= ST_PREFIX;
                     end else if (!cfg.bin_mode) begin
                        idx_ff <= '0;
                        state_ff <= ST_SPLIT;
                     end else begin
                        state_ff <= ST_STEP;
                        dvd_ff <= hi - lo;
                        dvs_ff <= KEY_BITS'(nb_ff - 1'b1);
                        rem_ff <= '0;
                        dcnt_ff <= '0;
                        miss_ff <= (hi < lo);
                     end
                  end
                  default: begin
                     rsp_full_ff <= 1'b1;
                     state_ff <= ST_IDLE;
                  end
               endcase
            end
            ST_PREFIX: begin
               // read one bin, then fold it into the running sum
               if (!rd_ok_ff) begin
                  count_rd_ff <= count_mem[idx_ff];
                  crd_valid_ff <= cvalid_ff[idx_ff];
                  rd_ok_ff <= 1'b1;
               end else begin
                  rd_ok_ff <= 1'b0;
                  if ({1'b0, idx_ff} < nb_ff) begin
                     offs_mem[idx_ff] <= run_ff;
                     run_ff <= sat_inc(run_ff, crd_valid_ff ? count_rd_ff : '0);
                  end else begin
                     offs_mem[idx_ff] <= '0;
                  end
                  if (idx_ff == BB'(MAX_BINS-1)) begin
                     phase_ff <= 1'b1;
                     idx_ff <= '0;
                     if (!cfg.bin_mode) begin
                        state_ff <= ST_SPLIT;
                     end else begin
                        state_ff <= ST_STEP;
                        dvd_ff <= hi - lo;
                        dvs_ff <= KEY_BITS'(nb_ff - 1'b1);
                        rem_ff <= '0;
                        dcnt_ff <= '0;
                        miss_ff <= (hi < lo);
                     end
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            ST_SPLIT: begin
               // linear scan of splitters, read then compare
               if (!rd_ok_ff) begin
                  split_rd_ff <= split_mem[idx_ff];
                  rd_ok_ff <= 1'b1;
               end else begin
                  rd_ok_ff <= 1'b0;
                  if (split_rd_ff >= key_m) begin
                     bin_ff <= idx_ff;
                     state_ff <= ST_BINRD;
                  end else if ({1'b0, idx_ff} + 1'b1 >= nb_ff) begin
                     rsp_ff.out_of_range <= 1'b1;
                     rsp_full_ff <= 1'b1;
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            ST_STEP, ST_QUOT: begin
               // restoring division, one bit per cycle
               if (dcnt_ff == $bits(dcnt_ff)'(KEY_BITS-1)) begin
                  dcnt_ff <= '0;
                  if (state_ff == ST_STEP) begin
                     if (miss_ff || (quo_bits == '0) || key_m < lo || key_m > hi) begin
                        rsp_ff.out_of_range <= 1'b1;
                        rsp_full_ff <= 1'b1;
                        state_ff <= ST_IDLE;
                     end else begin
                        dvd_ff <= key_m - lo;
                        dvs_ff <= quo_bits;
                        rem_ff <= '0;
                        state_ff <= ST_QUOT;
                     end
                  end else begin
                     if (quo_bits >= KEY_BITS'(nb_ff)) begin
                        rsp_ff.out_of_range <= 1'b1;
                        rsp_full_ff <= 1'b1;
                        state_ff <= ST_IDLE;
                     end else begin
                        bin_ff <= BB'(quo_bits);
                        state_ff <= ST_BINRD;
                     end
                  end
               end else begin
                  if (rem_sh >= {1'b0, dvs_ff}) begin
                     rem_ff <= rem_sh - {1'b0, dvs_ff};
                     dvd_ff <= {dvd_ff[KEY_BITS-2:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     dvd_ff <= {dvd_ff[KEY_BITS-2:0], 1'b0};
                  end
                  dcnt_ff <= dcnt_ff + 1'b1;
               end
            end
            ST_BINRD: begin
               // registered read of count and offset
               count_rd_ff <= count_mem[bin_ff];
               offs_rd_ff <= offs_mem[bin_ff];
               crd_valid_ff <= cvalid_ff[bin_ff];
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               rsp_ff.bin_number <= IDX_BITS'(bin_ff);
               case (req_ff.req_type)
                  REQ_COUNT: begin
                     count_mem[bin_ff] <= sat_inc(crd_valid_ff ? count_rd_ff : '0,
                                                  COUNT_BITS'(1));
                     cvalid_ff[bin_ff] <= 1'b1;
                     rsp_ff.bin_count <= CNTF_BITS'(sat_inc(crd_valid_ff ? count_rd_ff : '0,
                                                            COUNT_BITS'(1)));
                  end
                  REQ_PLACE: begin
                     rsp_ff.bin_count <= CNTF_BITS'(crd_valid_ff ? count_rd_ff : '0);
                     rsp_ff.dest_slot <= CNTF_BITS'(offs_rd_ff);
                     offs_mem[bin_ff] <= sat_inc(offs_rd_ff, COUNT_BITS'(1));
                  end
                  default: begin
                     rsp_ff.bin_count <= CNTF_BITS'(crd_valid_ff ? count_rd_ff : '0);
                     rsp_ff.dest_slot <= CNTF_BITS'(offs_rd_ff);
                  end
               endcase
               rsp_full_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- sv/splitter_histogram_partition.sv -----
// splitter_histogram_partition: histogram-sort binning engine
// req channel carries one word per operation: write splitter, clear
// histogram, count key, read bin or place key. every accepted word gives
// exactly one rsp word, in order.
// a two-entry queue decouples the accepting front from the executing back,
// so requests are taken while a finished result waits on rsp.
// work per word, from the back end taking it:
//   write, clear, unused codes, read out of range: answered from decode
//   read bin: a registered read of count and offset, then the answer
//   splitter mode: a read and a compare per splitter scanned (up to num_bins)
//   uniform mode: two 32-bit bit-serial divisions, step size then bin
//   first place after counting adds a prefix sweep over all 64 bins
// the shared bit-serial divider and the splitter scan set the pace.
// synchronous reset empties the queue, drops any result, zeroes all counts
// and restores register defaults. a stalled rsp holds its word and the
// back end stops; the queue then fills and req_ready falls.
// csr is an apb-style write/read port, registers at 0x0, 0x4, 0x8, 0xc.
module splitter_histogram_partition #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   shp_req_if.sink     req,
   shp_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [shp_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import shp_pkg::*;

   cfg_type      cfg_ff;
   logic         q_valid, q_pop;
   req_word_type q_word;

   assign csr_pready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bin_mode <= 1'b0;
         cfg_ff.num_bins <= 7'd64;
         cfg_ff.first_key <= '0;
         cfg_ff.last_key <= '1;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr)
            CSR_BIN_MODE:  cfg_ff.bin_mode <= csr_pwdata[0];
            CSR_NUM_BINS:  cfg_ff.num_bins <= csr_pwdata[6:0];
            CSR_FIRST_KEY: cfg_ff.first_key <= csr_pwdata;
            CSR_LAST_KEY:  cfg_ff.last_key <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (csr_paddr)
         CSR_BIN_MODE:  csr_prdata = {31'd0, cfg_ff.bin_mode};
         CSR_NUM_BINS:  csr_prdata = {25'd0, cfg_ff.num_bins};
         CSR_FIRST_KEY: csr_prdata = cfg_ff.first_key;
         CSR_LAST_KEY:  csr_prdata = cfg_ff.last_key;
         default:       csr_prdata = '0;
      endcase
   end

   shp_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .in_word  (req.payload),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_word   (q_word)
   );

   shp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_word    (q_word),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_word  (rsp.payload)
   );

endmodule

// ----- sv/shp_checker.sv -----
// port-level checks on the rsp channel and csr port
module shp_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [5:0] rsp_bin_number,
   input logic rsp_out_of_range,
   input logic [31:0] rsp_bin_count,
   input logic csr_pready
);

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp dropped while stalled");

   // an out-of-range result carries no bin and no count
   a_oor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_bin_count == 32'd0 && rsp_bin_number == 6'd0)
      else $error("out of range result with bin or count");

   // no result straight out of reset
   a_rst: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result after reset");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind splitter_histogram_partition shp_checker u_chk (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_bin_number   (rsp.payload.bin_number),
   .rsp_out_of_range (rsp.payload.out_of_range),
   .rsp_bin_count    (rsp.payload.bin_count),
   .csr_pready       (csr_pready)
);

// ----- tb/shp_bin_checker.sv -----
`timescale 1ns / 1ps

module shp_bin_checker (
   input  logic        clock,
   input  logic        reset,
   shp_req_if          req_mon,
   shp_rsp_if          rsp_mon,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [shp_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          waiting
);
   import shp_pkg::*;

   // shadow copy of the registers
   logic        mode_q;
   logic [6:0]  nbins_q;
   logic [31:0] lo_key_q;
   logic [31:0] hi_key_q;

   // shadow copy of the stores
   logic [31:0] split_tab [64];
   logic [31:0] counts    [64];
   logic [31:0] offsets   [64];
   logic        placing_q;

   rsp_word_type pending_results[$];

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic int bins_used();
      int nb;
      nb = nbins_q;
      if (nb < 2) nb = 2;
      if (nb > 64) nb = 64;
      return nb;
   endfunction

   // bin lookup in either mode, 0 when the key has no bin
   function automatic bit locate_bin(input logic [31:0] key, output logic [5:0] bin);
      int nb;
      logic [31:0] step;
      logic [31:0] q;
      nb = bins_used();
      bin = '0;
      if (!mode_q) begin
         for (int i = 0; i < nb; i++) begin
            if (split_tab[i] >= key) begin
               bin = 6'(i);
               return 1'b1;
            end
         end
         return 1'b0;
      end
      if (hi_key_q < lo_key_q) return 1'b0;
      step = (hi_key_q - lo_key_q) / 32'(nb - 1);
      if (step == 0) return 1'b0;
      if (key < lo_key_q || key > hi_key_q) return 1'b0;
      q = (key - lo_key_q) / step;
      if (q >= 32'(nb)) return 1'b0;
      bin = q[5:0];
      return 1'b1;
   endfunction

   // exclusive prefix offsets over the bins in use
   function automatic void build_offsets();
      logic [31:0] run;
      int nb;
      run = '0;
      nb = bins_used();
      for (int i = 0; i < 64; i++) begin
         if (i < nb) begin
            offsets[i] = run;
            run = sat_add(run, counts[i]);
         end else begin
            offsets[i] = '0;
         end
      end
   endfunction

   function automatic rsp_word_type bin_outcome(input req_word_type w);
      rsp_word_type r;
      logic [5:0] b;
      r = '0;
      case (w.req_type)
         REQ_WRITE_SPLIT: begin
            split_tab[w.bin_index] = w.key_value;
            r.bin_number = w.bin_index;
         end
         REQ_CLEAR: begin
            for (int i = 0; i < 64; i++) counts[i] = '0;
            placing_q = 1'b0;
         end
         REQ_COUNT: begin
            placing_q = 1'b0;
            if (locate_bin(w.key_value, b)) begin
               counts[b] = sat_add(counts[b], 32'd1);
               r.bin_number = b;
               r.bin_count = counts[b];
            end else begin
               r.out_of_range = 1'b1;
            end
         end
         REQ_READ: begin
            r.bin_number = w.bin_index;
            r.bin_count = counts[w.bin_index];
            r.dest_slot = offsets[w.bin_index];
         end
         REQ_PLACE: begin
            if (!placing_q) begin
               build_offsets();
               placing_q = 1'b1;
            end
            if (locate_bin(w.key_value, b)) begin
               r.bin_number = b;
               r.bin_count = counts[b];
               r.dest_slot = offsets[b];
               offsets[b] = sat_add(offsets[b], 32'd1);
            end else begin
               r.out_of_range = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // watch csr, req and rsp at each rising edge
   always @(posedge clock) begin
      rsp_word_type exp_w;
      rsp_word_type got_w;
      if (reset) begin
         mode_q    = 1'b0;
         nbins_q   = 7'd64;
         lo_key_q  = '0;
         hi_key_q  = 32'hFFFF_FFFF;
         placing_q = 1'b0;
         for (int i = 0; i < 64; i++) begin
            split_tab[i] = '0;
            counts[i]    = '0;
            offsets[i]   = '0;
         end
         pending_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               CSR_BIN_MODE:  mode_q = csr_pwdata[0];
               CSR_NUM_BINS:  nbins_q = csr_pwdata[6:0];
               CSR_FIRST_KEY: lo_key_q = csr_pwdata;
               CSR_LAST_KEY:  hi_key_q = csr_pwdata;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_w = rsp_mon.payload;
            if (pending_results.size() == 0) begin
               $error("result word with nothing expected: %p", got_w);
               fail_count++;
            end else begin
               exp_w = pending_results.pop_front();
               if (got_w.bin_number !== exp_w.bin_number) begin
                  $error("bin_number expected %0d got %0d", exp_w.bin_number, got_w.bin_number);
                  fail_count++;
               end
               if (got_w.bin_count !== exp_w.bin_count) begin
                  $error("bin_count expected %0d got %0d", exp_w.bin_count, got_w.bin_count);
                  fail_count++;
               end
               if (got_w.dest_slot !== exp_w.dest_slot) begin
                  $error("dest_slot expected %0d got %0d", exp_w.dest_slot, got_w.dest_slot);
                  fail_count++;
               end
               if (got_w.out_of_range !== exp_w.out_of_range) begin
                  $error("out_of_range expected %0d got %0d",
                         exp_w.out_of_range, got_w.out_of_range);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_results.push_back(bin_outcome(req_mon.payload));
      end
      waiting = pending_results.size();
   end

   initial begin
      fail_count = 0;
      waiting = 0;
   end

endmodule

// ----- tb/tb_splitter_histogram_partition.sv -----
`timescale 1ns / 1ps

module tb_splitter_histogram_partition;
   import shp_pkg::*;

   localparam logic [REQ_BITS-1:0] REQ_SPARE_A = 3'd5;
   localparam logic [REQ_BITS-1:0] REQ_SPARE_B = 3'd6;
   localparam logic [REQ_BITS-1:0] REQ_SPARE_C = 3'd7;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          waiting;

   bit          idle_on;
   bit          offsets_ready;
   int          words_sent;
   int          phases;
   logic        cur_mode;
   logic [31:0] key_lo;
   logic [31:0] key_hi;

   shp_req_if req_bus ();
   shp_rsp_if rsp_bus ();

   splitter_histogram_partition u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   shp_bin_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .fail_count  (fail_count),
      .waiting     (waiting)
   );

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // result side back-pressure
   always @(negedge clock) begin
      rsp_bus.ready <= idle_on ? ($urandom_range(99) >= 11) : 1'b1;
   end

   // overall time limit
   initial begin
      #30_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_word(input logic [REQ_BITS-1:0] t, input logic [5:0] idx,
                            input logic [31:0] key);
      req_word_type w;
      w.req_type = t;
      w.bin_index = idx;
      w.key_value = key;
      if (idle_on && $urandom_range(99) < 11) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.payload <= w;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
      if (t == REQ_PLACE) offsets_ready = 1'b1;
   endtask

   task automatic csr_write(input csr_addr_type a, input logic [31:0] d);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= a;
      csr_pwdata <= d;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // let every word drain, then allow for a silent tail of work
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (waiting != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic set_uniform(input logic [6:0] nb, input logic [31:0] lo, input logic [31:0] hi);
      csr_write(CSR_BIN_MODE, 32'd1);
      csr_write(CSR_NUM_BINS, {25'd0, nb});
      csr_write(CSR_FIRST_KEY, lo);
      csr_write(CSR_LAST_KEY, hi);
      cur_mode = 1'b1;
      key_lo = lo;
      key_hi = hi;
   endtask

   // mostly keys that land in a bin, now and then anything
   function automatic logic [31:0] pick_key();
      if ($urandom_range(99) < 10) return $urandom;
      if (cur_mode && key_hi >= key_lo) return $urandom_range(key_hi, key_lo);
      return $urandom_range(key_hi, 0);
   endfunction

   initial begin
      logic [31:0] split_q[$];
      logic [31:0] keys_q[$];
      logic [31:0] span;
      logic [6:0]  nb;
      logic [REQ_BITS-1:0] t;
      int m;

      reset = 1'b1;
      idle_on = 1'b1;
      offsets_ready = 1'b0;
      words_sent = 0;
      phases = 0;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every splitter gets a value before any lookup: an even ramp
      cur_mode = 1'b0;
      key_lo = '0;
      key_hi = 32'hFFFF_FFFF;
      csr_write(CSR_BIN_MODE, 32'd0);
      csr_write(CSR_NUM_BINS, 32'd64);
      for (int i = 0; i < 64; i++)
         send_word(REQ_WRITE_SPLIT, 6'(i), (32'(i) << 26) | 32'h03FF_FFFF);

      // directed: key extremes, every code, splitter miss
      send_word(REQ_COUNT, 6'd0, 32'd0);
      send_word(REQ_COUNT, 6'd63, 32'hFFFF_FFFF);
      send_word(REQ_PLACE, 6'd0, 32'd0);
      send_word(REQ_READ, 6'd0, 32'd0);
      send_word(REQ_READ, 6'd63, 32'hFFFF_FFFF);
      send_word(REQ_WRITE_SPLIT, 6'd63, 32'h7FFF_FFFF);
      send_word(REQ_COUNT, 6'd0, 32'hFFFF_FFFF);
      send_word(REQ_PLACE, 6'd0, 32'hFFFF_FFFF);
      send_word(REQ_SPARE_A, 6'd63, 32'hFFFF_FFFF);
      send_word(REQ_SPARE_B, 6'd21, 32'h5555_5555);
      send_word(REQ_SPARE_C, 6'd42, 32'hAAAA_AAAA);
      send_word(REQ_CLEAR, 6'd0, 32'd0);
      send_word(REQ_READ, 6'd5, 32'd0);
      send_word(REQ_WRITE_SPLIT, 6'd63, 32'hFFFF_FFFF);
      settle();

      // directed uniform: reversed range, zero step, out of range, both ends
      set_uniform(7'd64, 32'd100, 32'd50);
      send_word(REQ_COUNT, 6'd0, 32'd70);
      settle();
      set_uniform(7'd64, 32'd100, 32'd110);
      send_word(REQ_COUNT, 6'd0, 32'd105);
      settle();
      set_uniform(7'd2, 32'd1000, 32'hFFFF_FFFF);
      send_word(REQ_COUNT, 6'd0, 32'd999);
      send_word(REQ_COUNT, 6'd0, 32'd1000);
      send_word(REQ_COUNT, 6'd0, 32'hFFFF_FFFF);
      send_word(REQ_PLACE, 6'd0, 32'hFFFF_FFFF);
      send_word(REQ_READ, 6'd1, 32'd0);
      settle();

      // random phases of well-formed count and place runs with some noise
      while (words_sent < 420) begin
         phases++;
         idle_on = !(phases >= 4 && phases <= 7);
         case ($urandom_range(2))
            0: nb = 7'd2;
            1: nb = 7'd64;
            default: nb = 7'($urandom_range(64, 2));
         endcase
         if ($urandom_range(1)) begin
            case ($urandom_range(3))
               0: span = $urandom_range(200);
               1: span = $urandom;
               2: span = 32'hFFFF_FFFF;
               default: span = $urandom_range(5000, 60);
            endcase
            key_lo = $urandom_range(3) == 0 ? 32'd0 : $urandom;
            if ($urandom_range(9) == 0)
               key_hi = key_lo - 32'd1;
            else
               key_hi = (key_lo > ~span) ? 32'hFFFF_FFFF : key_lo + span;
            set_uniform(nb, key_lo, key_hi);
         end else begin
            csr_write(CSR_BIN_MODE, 32'd0);
            csr_write(CSR_NUM_BINS, {25'd0, nb});
            csr_write(CSR_FIRST_KEY, $urandom);
            csr_write(CSR_LAST_KEY, $urandom);
            cur_mode = 1'b0;
            split_q.delete();
            for (int i = 0; i < nb; i++) split_q.push_back($urandom);
            if ($urandom_range(1)) split_q[0] = 32'hFFFF_FFFF;
            split_q.sort();
            key_hi = split_q[nb - 1];
            for (int i = 0; i < nb; i++) send_word(REQ_WRITE_SPLIT, 6'(i), split_q[i]);
         end

         // count pass
         send_word(REQ_CLEAR, 6'($urandom), $urandom);
         keys_q.delete();
         m = $urandom_range(30, 4);
         for (int i = 0; i < m; i++) begin
            keys_q.push_back(pick_key());
            send_word(REQ_COUNT, 6'($urandom), keys_q[i]);
            if ($urandom_range(99) < 8) begin
               t = 3'($urandom_range(7));
               if (t == REQ_WRITE_SPLIT || (t == REQ_READ && !offsets_ready)) t = REQ_COUNT;
               send_word(t, 6'($urandom), pick_key());
            end
         end

         // place pass in scrambled order, then read back some bins
         keys_q.shuffle();
         foreach (keys_q[i]) send_word(REQ_PLACE, 6'($urandom), keys_q[i]);
         repeat ($urandom_range(6, 1)) send_word(REQ_READ, 6'($urandom), $urandom);
         settle();
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (waiting != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      $display("covered %0d request words over %0d random phases", words_sent, phases);
      $display("both binning modes, bin counts from 2 to 64, with stalls on both sides");
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
